// ----- hw/rtl/gnmc_pkg.sv -----
// ----------------------------------------------------------------------------
// gnmc_pkg
// Shared limits, widths and character codes of the grid neighbor mine counter.
// ----------------------------------------------------------------------------
package gnmc_pkg;

  // frame limits
  localparam int unsigned MAX_COLS = 128;
  localparam int unsigned MAX_ROWS = 128;

  localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // frame size registers and cell characters are byte wide
  localparam int unsigned DIM_W  = 8;
  localparam int unsigned CHAR_W = 8;

  // wide enough for register values and both limits (limits up to 1024)
  localparam int unsigned CMP_W = 11;

  // three row stores, one bit each per column
  localparam int unsigned NUM_ROW_STORES = 3;
  typedef logic [NUM_ROW_STORES-1:0] col_word_t;

  // an item causes at most this many results
  localparam int unsigned MAX_RES   = 4;
  localparam int unsigned RES_IDX_W = $clog2(MAX_RES);
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

  // register port
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned PADDR_W   = REG_IDX_W + 2;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_ROWS = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_FRAME_COLS = REG_IDX_W'(1);

  // character codes
  localparam logic [CHAR_W-1:0] MINE_CHAR  = 8'd42;
  localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] DIGIT_MAX  = 8'd56;

endpackage

// ----- hw/rtl/gnmc_ram.sv -----
// ----------------------------------------------------------------------------
// gnmc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gnmc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/grid_neighbor_mine_count_core.sv -----
// Result path: the column word is read as the item is accepted, then the
// results it completes are registered in the output buffer and shown.
// Throughput: one item per cycle while no item causes more than one result
// and the output is not stalled; several results queue for the single port.
// Reset: position counters go to the frame origin, both frame sizes to 1,
// and the per-column valid bits of the row stores clear at once (all empty).
// ----------------------------------------------------------------------------
// grid_neighbor_mine_count_core
// Raster-order 3x3 neighbor mine counter. The three row stores live in one
// RAM indexed by column; each item reads, updates and writes back its column.
// ----------------------------------------------------------------------------
module grid_neighbor_mine_count_core
  import gnmc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,

  // cell items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CHAR_W-1:0]  cell_char_i,

  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CHAR_W-1:0]  out_char_o,
  output logic               row_end_o,
  output logic               frame_end_o,
  output logic               run_last_o
);

  localparam logic [1:0] RMOD_FIRST = 2'd0;
  localparam logic [1:0] RMOD_MID   = 2'd1;
  localparam logic [1:0] RMOD_LAST  = 2'd2;

  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic r_last;
    logic c_ge1;
    logic c_ge2;
    logic c_last;
  } pos_flags_t;

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  // reorder a column word so bit 2 is the newest row, bit 0 the oldest
  function automatic col_word_t rotate_col(col_word_t w, logic [1:0] rmod);
    col_word_t res;
    case (rmod)
      RMOD_FIRST: res = {w[0], w[2], w[1]};
      RMOD_MID:   res = {w[1], w[0], w[2]};
      RMOD_LAST:  res = {w[2], w[1], w[0]};
      default:    res = '0;
    endcase
    return res;
  endfunction

  // left, middle, right columns: bit 0 above, bit 1 center, bit 2 below
  function automatic logic [CHAR_W-1:0] cell_result(col_word_t l, col_word_t m,
                                                    col_word_t r);
    logic [3:0] cnt;
    cnt = 4'(l[0]) + 4'(l[1]) + 4'(l[2]) + 4'(m[0]) + 4'(m[2])
        + 4'(r[0]) + 4'(r[1]) + 4'(r[2]);
    return m[1] ? MINE_CHAR : DIGIT_ZERO + CHAR_W'(cnt);
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0] rows_q, cols_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_W'(1);
      cols_q <= DIM_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[PADDR_W-1:2])
        REG_FRAME_ROWS: rows_q <= pwdata[DIM_W-1:0];
        REG_FRAME_COLS: cols_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[PADDR_W-1:2])
      REG_FRAME_ROWS: prdata[DIM_W-1:0] = rows_q;
      REG_FRAME_COLS: prdata[DIM_W-1:0] = cols_q;
      default: ;
    endcase
  end

  // effective frame size: zero reads as one, large values saturate
  logic [CMP_W-1:0] nr, nc;

  always_comb begin
    if (rows_q == '0) begin
      nr = CMP_W'(1);
    end else if (CMP_W'(rows_q) > CMP_W'(MAX_ROWS)) begin
      nr = CMP_W'(MAX_ROWS);
    end else begin
      nr = CMP_W'(rows_q);
    end
    if (cols_q == '0) begin
      nc = CMP_W'(1);
    end else if (CMP_W'(cols_q) > CMP_W'(MAX_COLS)) begin
      nc = CMP_W'(MAX_COLS);
    end else begin
      nc = CMP_W'(cols_q);
    end
  end

  // --------------------------------------------------------------------------
  // input position
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] in_row_q, in_row_d, r_eff;
  logic [COL_W-1:0] in_col_q, in_col_d, c_eff;
  logic [1:0]       rmod_q, rmod_d, rmod_eff;
  logic             restart;
  logic [CMP_W-1:0] c_nx, r_nx;
  pos_flags_t       acc_flags;
  logic             in_accept;

  assign in_accept = in_valid_i & ~in_stall_o;

  always_comb begin
    // counters outside a shrunk frame restart it
    restart  = (CMP_W'(in_row_q) >= nr) || (CMP_W'(in_col_q) >= nc);
    r_eff    = restart ? '0 : in_row_q;
    c_eff    = restart ? '0 : in_col_q;
    rmod_eff = restart ? RMOD_FIRST : rmod_q;

    acc_flags.r_ge1  = (r_eff != '0);
    acc_flags.r_ge2  = (CMP_W'(r_eff) > CMP_W'(1));
    acc_flags.r_last = (CMP_W'(r_eff) == nr - CMP_W'(1));
    acc_flags.c_ge1  = (c_eff != '0);
    acc_flags.c_ge2  = (CMP_W'(c_eff) > CMP_W'(1));
    acc_flags.c_last = (CMP_W'(c_eff) == nc - CMP_W'(1));

    c_nx = CMP_W'(c_eff) + CMP_W'(1);
    r_nx = CMP_W'(r_eff) + CMP_W'(1);
    in_row_d = r_eff;
    in_col_d = c_nx[COL_W-1:0];
    rmod_d   = rmod_eff;
    if (c_nx >= nc) begin
      in_col_d = '0;
      if (r_nx >= nr) begin
        in_row_d = '0;
        rmod_d   = RMOD_FIRST;
      end else begin
        in_row_d = r_nx[ROW_W-1:0];
        rmod_d   = (rmod_eff == RMOD_LAST) ? RMOD_FIRST : rmod_eff + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q <= '0;
      in_col_q <= '0;
      rmod_q   <= RMOD_FIRST;
    end else if (in_accept) begin
      in_row_q <= in_row_d;
      in_col_q <= in_col_d;
      rmod_q   <= rmod_d;
    end
  end

  // --------------------------------------------------------------------------
  // row store RAM: one word per column, one bit per row store
  // --------------------------------------------------------------------------
  logic             ram_we;
  logic [COL_W-1:0] ram_waddr;
  col_word_t        ram_wdata, ram_rdata;
  logic [MAX_COLS-1:0] col_valid_q;

  gnmc_ram #(
    .WIDTH (NUM_ROW_STORES),
    .DEPTH (MAX_COLS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (c_eff),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // stage 1: column update and result computation
  // --------------------------------------------------------------------------
  logic             s1_valid_q;
  logic [COL_W-1:0] s1_col_q;
  logic [1:0]       s1_rmod_q;
  logic             s1_mine_q;
  pos_flags_t       s1_flags_q;
  logic             s1_fresh_q;
  logic             s1_ent_vld_q;
  col_word_t        s1_hold_q;
  col_word_t        win_c1_q, win_c2_q;

  col_word_t        col_raw, col_new, cur;
  col_word_t        a_l, a_m, a_r, b_l, b_m, b_r;
  col_word_t        c_l, c_m, c_r, d_l, d_m, d_r;
  logic [CHAR_W-1:0] res_char [MAX_RES];
  logic [MAX_RES-1:0] res_en, res_row_end, res_frame_end;
  logic [CHAR_W-1:0] pk_char [MAX_RES];
  logic [MAX_RES-1:0] pk_row_end, pk_frame_end;
  logic [RES_CNT_W-1:0] s1_n;
  logic             s1_adv, fwd;

  logic [CHAR_W-1:0] ob_char_q [MAX_RES];
  logic [MAX_RES-1:0] ob_row_end_q, ob_frame_end_q;
  logic [RES_CNT_W-1:0] ob_cnt_q;
  logic             out_take, ob_free;

  always_comb begin
    col_raw = s1_fresh_q ? (ram_rdata & {NUM_ROW_STORES{s1_ent_vld_q}}) : s1_hold_q;
    col_new = col_raw;
    col_new[s1_rmod_q] = s1_mine_q;
    cur = rotate_col(col_new, s1_rmod_q);
  end

  always_comb begin
    // cell one row up, one column left
    a_l = s1_flags_q.c_ge2 ? win_c2_q : '0;
    a_m = win_c1_q;
    a_r = cur;
    a_l = {a_l[2], a_l[1], a_l[0] & s1_flags_q.r_ge2};
    a_m = {a_m[2], a_m[1], a_m[0] & s1_flags_q.r_ge2};
    a_r = {a_r[2], a_r[1], a_r[0] & s1_flags_q.r_ge2};
    // cell one row up, last column
    b_l = s1_flags_q.c_ge1 ? win_c1_q : '0;
    b_m = cur;
    b_r = '0;
    b_l = {b_l[2], b_l[1], b_l[0] & s1_flags_q.r_ge2};
    b_m = {b_m[2], b_m[1], b_m[0] & s1_flags_q.r_ge2};
    // last row: nothing below, the newest row is the center
    c_l = s1_flags_q.c_ge2 ? win_c2_q : '0;
    c_m = win_c1_q;
    c_r = cur;
    c_l = {1'b0, c_l[2], c_l[1] & s1_flags_q.r_ge1};
    c_m = {1'b0, c_m[2], c_m[1] & s1_flags_q.r_ge1};
    c_r = {1'b0, c_r[2], c_r[1] & s1_flags_q.r_ge1};
    d_l = s1_flags_q.c_ge1 ? win_c1_q : '0;
    d_m = cur;
    d_r = '0;
    d_l = {1'b0, d_l[2], d_l[1] & s1_flags_q.r_ge1};
    d_m = {1'b0, d_m[2], d_m[1] & s1_flags_q.r_ge1};

    res_char[0] = cell_result(a_l, a_m, a_r);
    res_char[1] = cell_result(b_l, b_m, b_r);
    res_char[2] = cell_result(c_l, c_m, c_r);
    res_char[3] = cell_result(d_l, d_m, d_r);

    res_en[0] = s1_flags_q.r_ge1  & s1_flags_q.c_ge1;
    res_en[1] = s1_flags_q.r_ge1  & s1_flags_q.c_last;
    res_en[2] = s1_flags_q.r_last & s1_flags_q.c_ge1;
    res_en[3] = s1_flags_q.r_last & s1_flags_q.c_last;

    res_row_end   = 4'b1010;
    res_frame_end = 4'b1000;
  end

  // pack the enabled results to the front, in order
  always_comb begin
    s1_n         = '0;
    pk_row_end   = '0;
    pk_frame_end = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      pk_char[i] = '0;
    end
    for (int i = 0; i < MAX_RES; i++) begin
      if (res_en[i]) begin
        pk_char[s1_n[RES_IDX_W-1:0]]      = res_char[i];
        pk_row_end[s1_n[RES_IDX_W-1:0]]   = res_row_end[i];
        pk_frame_end[s1_n[RES_IDX_W-1:0]] = res_frame_end[i];
        s1_n = s1_n + RES_CNT_W'(1);
      end
    end
  end

  assign out_take   = out_valid_o & ~out_stall_i;
  assign ob_free    = (ob_cnt_q == '0) || ((ob_cnt_q == RES_CNT_W'(1)) && out_take);
  assign s1_adv     = s1_valid_q && ((s1_n == '0) || ob_free);
  assign in_stall_o = s1_valid_q && !s1_adv;

  // the new read sees old data when the write to its column lands the same edge
  assign fwd = s1_adv && (s1_col_q == c_eff);

  assign ram_we    = s1_adv;
  assign ram_waddr = s1_col_q;
  assign ram_wdata = col_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_fresh_q  <= 1'b0;
      col_valid_q <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        s1_fresh_q <= !fwd;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end else if (s1_valid_q) begin
        s1_fresh_q <= 1'b0;
      end
      if (s1_adv) begin
        col_valid_q[s1_col_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_col_q     <= c_eff;
      s1_rmod_q    <= rmod_eff;
      s1_mine_q    <= (cell_char_i == MINE_CHAR);
      s1_flags_q   <= acc_flags;
      s1_ent_vld_q <= col_valid_q[c_eff];
      s1_hold_q    <= col_new;
    end else if (s1_valid_q && !s1_adv && s1_fresh_q) begin
      s1_hold_q <= col_raw;
    end
    if (s1_adv) begin
      win_c2_q <= win_c1_q;
      win_c1_q <= cur;
    end
  end

  // --------------------------------------------------------------------------
  // output buffer: results of one item, head at entry 0
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_cnt_q <= '0;
    end else if (s1_adv && (s1_n != '0)) begin
      ob_cnt_q <= s1_n;
    end else if (out_take) begin
      ob_cnt_q <= ob_cnt_q - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (s1_n != '0)) begin
      ob_char_q      <= pk_char;
      ob_row_end_q   <= pk_row_end;
      ob_frame_end_q <= pk_frame_end;
    end else if (out_take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        ob_char_q[i]      <= ob_char_q[i+1];
        ob_row_end_q[i]   <= ob_row_end_q[i+1];
        ob_frame_end_q[i] <= ob_frame_end_q[i+1];
      end
    end
  end

  assign out_valid_o = (ob_cnt_q != '0);
  assign out_char_o  = ob_char_q[0];
  assign row_end_o   = ob_row_end_q[0];
  assign frame_end_o = ob_frame_end_q[0];
  assign run_last_o  = (ob_cnt_q == RES_CNT_W'(1));

endmodule

// ----- hw/rtl/gnmc_checker.sv -----
// ----------------------------------------------------------------------------
// gnmc_checker
// Port-level checks of the grid neighbor mine counter, bound to the top level.
// ----------------------------------------------------------------------------
module gnmc_checker
  import gnmc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [CHAR_W-1:0]  out_char_o,
  input logic               row_end_o,
  input logic               frame_end_o,
  input logic               run_last_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o)
      && $stable(run_last_o))
    else $error("stalled result changed");

  // results are a mine or a digit from zero to eight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_char_o == MINE_CHAR)
      || ((out_char_o >= DIGIT_ZERO) && (out_char_o <= DIGIT_MAX)))
    else $error("result character out of range");

  // the last cell of a frame closes its row and its item's run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o && run_last_o)
    else $error("frame end without row end or run end");

  // results of one item come without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o)
    else $error("gap inside an item's results");

endmodule

bind grid_neighbor_mine_count_core gnmc_checker u_gnmc_checker (.*);

// ----- tb/mine_count_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mine_count_checker
// Watches the register port and both item channels of the mine counter.
// Keeps its own copy of the row stores, the position and the frame size,
// predicts the cells each accepted item completes, and compares every
// accepted result field by field with the oldest prediction. Register
// reads are checked against the last value written.
// ----------------------------------------------------------------------------
module mine_count_checker
  import gnmc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  input  logic [PDATA_W-1:0] prdata_i,
  input  logic               pready_i,

  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [CHAR_W-1:0]  cell_char_i,

  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [CHAR_W-1:0]  out_char_i,
  input  logic               row_end_i,
  input  logic               frame_end_i,
  input  logic               run_last_i,

  output int                 mismatches_o,
  output int                 results_due_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              row_end;
    logic              frame_end;
    logic              run_last;
  } cell_result_t;

  cell_result_t     expected_cells[$];
  cell_result_t     oldest;
  logic             mine_rows [NUM_ROW_STORES][MAX_COLS];
  logic [DIM_W-1:0] rows_reg;
  logic [DIM_W-1:0] cols_reg;
  logic [DIM_W-1:0] reg_want;
  int               cur_row;
  int               cur_col;

  task automatic report_fail(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches_o++;
  endtask

  // zero reads as one, anything above the limit saturates
  function automatic int dim_limit(input logic [DIM_W-1:0] v, input int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic bit mine_at(input int r, input int c, input int nr, input int nc);
    if (r < 0 || c < 0 || r >= nr || c >= nc) return 1'b0;
    return mine_rows[r % NUM_ROW_STORES][c];
  endfunction

  function automatic cell_result_t count_cell(input int r, input int c, input int nr,
                                              input int nc, input bit last);
    cell_result_t res;
    int           cnt;
    cnt = 0;
    if (mine_at(r, c, nr, nc)) begin
      res.ch = MINE_CHAR;
    end else begin
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          if (dr != 0 || dc != 0) cnt += int'(mine_at(r + dr, c + dc, nr, nc));
        end
      end
      res.ch = DIGIT_ZERO + CHAR_W'(cnt);
    end
    res.row_end   = (c == nc - 1);
    res.frame_end = (r == nr - 1) && (c == nc - 1);
    res.run_last  = last;
    return res;
  endfunction

  // store the cell, then queue the cells it completes: the row above first,
  // then on the last row the row itself
  task automatic predict_item(input logic [CHAR_W-1:0] ch);
    int nr;
    int nc;
    int r;
    int c;
    int n;
    int rr[MAX_RES];
    int cc[MAX_RES];
    nr = dim_limit(rows_reg, MAX_ROWS);
    nc = dim_limit(cols_reg, MAX_COLS);
    if (cur_row >= nr || cur_col >= nc) begin
      cur_row = 0;
      cur_col = 0;
    end
    r = cur_row;
    c = cur_col;
    n = 0;
    mine_rows[r % NUM_ROW_STORES][c] = (ch == MINE_CHAR);
    if (r >= 1) begin
      if (c >= 1) begin
        rr[n] = r - 1; cc[n] = c - 1; n++;
      end
      if (c == nc - 1) begin
        rr[n] = r - 1; cc[n] = c; n++;
      end
    end
    if (r == nr - 1) begin
      if (c >= 1) begin
        rr[n] = r; cc[n] = c - 1; n++;
      end
      if (c == nc - 1) begin
        rr[n] = r; cc[n] = c; n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      expected_cells.push_back(count_cell(rr[k], cc[k], nr, nc, k == n - 1));
    end
    c++;
    if (c >= nc) begin
      c = 0;
      r++;
      if (r >= nr) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_ROW_STORES; s++) begin
        for (int i = 0; i < MAX_COLS; i++) mine_rows[s][i] = 1'b0;
      end
      expected_cells.delete();
      rows_reg      = DIM_W'(1);
      cols_reg      = DIM_W'(1);
      cur_row       = 0;
      cur_col       = 0;
      mismatches_o  = 0;
      results_due_o = 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[PADDR_W-1:2] == REG_FRAME_ROWS) rows_reg = pwdata_i[DIM_W-1:0];
          else cols_reg = pwdata_i[DIM_W-1:0];
        end else begin
          reg_want = (paddr_i[PADDR_W-1:2] == REG_FRAME_ROWS) ? rows_reg : cols_reg;
          if (prdata_i !== PDATA_W'(reg_want))
            report_fail($sformatf("register read at %0h gave %0h, want %0h",
                                  paddr_i, prdata_i, reg_want));
        end
      end

      if (out_valid_i && !out_stall_i) begin
        if (expected_cells.size() == 0) begin
          report_fail($sformatf("result %0h arrived with none pending", out_char_i));
        end else begin
          oldest = expected_cells.pop_front();
          if (out_char_i !== oldest.ch)
            report_fail($sformatf("out_char %0h, want %0h", out_char_i, oldest.ch));
          if (row_end_i !== oldest.row_end)
            report_fail($sformatf("row_end %0b, want %0b", row_end_i, oldest.row_end));
          if (frame_end_i !== oldest.frame_end)
            report_fail($sformatf("frame_end %0b, want %0b", frame_end_i,
                                  oldest.frame_end));
          if (run_last_i !== oldest.run_last)
            report_fail($sformatf("run_last %0b, want %0b", run_last_i, oldest.run_last));
        end
      end

      if (in_valid_i && !in_stall_i) predict_item(cell_char_i);
      results_due_o = expected_cells.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the mine counter through a series of frame sizes: single cells,
// zero and oversized registers, a full neighborhood, a frame shrunk while
// partway fed, one full-width row under a long output hold, then random small
// frames, some of them cut short. Both sides idle at random. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import gnmc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [CHAR_W-1:0] EMPTY_CHAR = 8'h2e;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [CHAR_W-1:0]  cell_char;
  logic               out_valid;
  logic               out_stall;
  logic [CHAR_W-1:0]  out_char;
  logic               row_end;
  logic               frame_end;
  logic               run_last;

  logic rand_stall;
  logic long_hold;
  bit   hold_go;
  bit   send_calm;
  int   mismatches;
  int   results_due;
  int   cycles;

  assign out_stall = rand_stall | long_hold;

  grid_neighbor_mine_count_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cell_char_i (cell_char),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_char_o  (out_char),
    .row_end_o   (row_end),
    .frame_end_o (frame_end),
    .run_last_o  (run_last)
  );

  mine_count_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_i      (prdata),
    .pready_i      (pready),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .cell_char_i   (cell_char),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_char_i    (out_char),
    .row_end_i     (row_end),
    .frame_end_i   (frame_end),
    .run_last_i    (run_last),
    .mismatches_o  (mismatches),
    .results_due_o (results_due)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall before each item, with calm stretches
  initial begin
    int unsigned wait_len;
    bit          calm;
    rand_stall = 1'b0;
    calm       = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 15) == 0) calm = !calm;
      wait_len = calm ? 0 : $urandom_range(0, 19);
      if (wait_len > 0) begin
        rand_stall <= 1'b1;
        repeat (wait_len) @(negedge clk);
        rand_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // long output hold so the block backs up into its input
  initial begin
    long_hold = 1'b0;
    wait (hold_go);
    @(negedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    long_hold <= 1'b0;
  end

  // called at a falling edge, returns at a falling edge with the port idle
  task automatic reg_access(input bit wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [DIM_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= PDATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic frame_setup(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
    reg_access(1'b1, REG_FRAME_ROWS, rows);
    reg_access(1'b1, REG_FRAME_COLS, cols);
    reg_access(1'b0, REG_FRAME_ROWS, '0);
    reg_access(1'b0, REG_FRAME_COLS, '0);
  endtask

  // valid stays high into the next item unless a gap is drawn
  task automatic send_cell(input logic [CHAR_W-1:0] ch);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    cell_char <= ch;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // items that complete no cell may still be in flight, so drain a little
  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (results_due == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] rand_cell();
    if ($urandom_range(0, 99) < 35) return MINE_CHAR;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  initial begin
    int nr;
    int nc;
    int cells;
    int rand_items;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    cell_char = '0;
    hold_go   = 1'b0;
    send_calm = 1'b0;
    cycles    = 0;
    rand_items = 0;
    rst_n     = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset size: every item is a whole frame of one cell
    reg_access(1'b0, REG_FRAME_ROWS, '0);
    reg_access(1'b0, REG_FRAME_COLS, '0);
    send_cell(MINE_CHAR);
    send_cell(8'h00);
    send_cell(8'hff);
    send_cell(DIGIT_ZERO);
    send_cell(MINE_CHAR + 8'd1);
    send_cell(MINE_CHAR - 8'd1);
    send_cell(8'h55);
    send_cell(8'haa);
    wait_idle();

    // zero registers read as one
    frame_setup(8'd0, 8'd0);
    send_cell(MINE_CHAR);
    send_cell(8'h0f);
    wait_idle();

    // ring of mines around an empty center gives the highest count
    frame_setup(8'd3, 8'd4);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        send_cell((c < 3 && !(r == 1 && c == 1)) ? MINE_CHAR : EMPTY_CHAR);
      end
    end
    wait_idle();

    // oversized frame fed partway, then shrunk so the position restarts
    frame_setup(8'd255, 8'd255);
    repeat (20) send_cell(rand_cell());
    wait_idle();
    frame_setup(8'd2, 8'd3);
    repeat (6) send_cell(rand_cell());
    wait_idle();

    // one full-width row, output held off for a long stretch meanwhile
    frame_setup(8'd1, 8'd200);
    for (int i = 0; i < MAX_COLS; i++) begin
      if (i == 10) hold_go = 1'b1;
      send_cell(rand_cell());
    end
    wait_idle();

    // random small frames, some cut short and left for the next size
    while (rand_items < 100) begin
      nr = $urandom_range(1, 5);
      nc = $urandom_range(1, 8);
      frame_setup(DIM_W'(nr), DIM_W'(nc));
      cells = nr * nc * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) cells = $urandom_range(1, nr * nc);
      repeat (cells) send_cell(rand_cell());
      rand_items += cells;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/gnmc_pkg.sv
hw/rtl/gnmc_ram.sv
hw/rtl/grid_neighbor_mine_count_core.sv
hw/rtl/gnmc_checker.sv
tb/mine_count_checker.sv
tb/testbench.sv
